@@ rtl/core/lfrbs_pkg.sv @@
// Shared types, constants and helpers for the LCD fill-rectangle byte sequencer.
// Used by lfrbs_clip and lcd_fill_rect_byte_sequencer_unit; no dependencies.
`timescale 1ns / 1ps

package lfrbs_pkg;

	// Default largest panel dimension.
	localparam int MAX_DIM_DEF = 1024;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PANEL_WIDTH  = 1'b0,
		REG_PANEL_HEIGHT = 1'b1
	} cfg_reg_t;

	// Request kinds, carried on the input tuser.
	typedef enum logic [1:0] {
		KIND_FILL    = 2'd0,
		KIND_ROTATE  = 2'd1,
		KIND_INVERT  = 2'd2,
		KIND_ADVANCE = 2'd3
	} kind_t;

	// Input tdata layout, lowest bit first.
	localparam int FLD_W       = 16;
	localparam int OFS_RECT_X  = 0;
	localparam int OFS_RECT_Y  = 16;
	localparam int OFS_RECT_W  = 32;
	localparam int OFS_RECT_H  = 48;
	localparam int OFS_COLOR   = 64;
	localparam int OFS_ROT     = 80;
	localparam int ROT_W       = 8;
	localparam int OFS_INVERT  = 88;
	localparam int S_TDATA_W   = 96;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 8;
	localparam int M_TUSER_W   = 2;

	// Normalized coordinate width (covers x + w + 1 and x + w - 1 of 16-bit operands).
	localparam int GEO_W = 18;

	// Panel command codes.
	localparam logic [7:0] CMD_CASET  = 8'h2A;
	localparam logic [7:0] CMD_PASET  = 8'h2B;
	localparam logic [7:0] CMD_RAMWR  = 8'h2C;
	localparam logic [7:0] CMD_MADCTL = 8'h36;
	localparam logic [7:0] CMD_INVOFF = 8'h20;
	localparam logic [7:0] CMD_INVON  = 8'h21;

	// Memory-access-control bits.
	localparam logic [7:0] ACC_ROW_FLIP  = 8'h80;
	localparam logic [7:0] ACC_COL_FLIP  = 8'h40;
	localparam logic [7:0] ACC_AXIS_SWAP = 8'h20;
	localparam logic [7:0] ACC_BGR_ORDER = 8'h08;

	// Sequencer phases, one-hot.
	typedef enum logic [15:0] {
		PH_IDLE   = 16'h0001,
		PH_CASET  = 16'h0002,
		PH_XS_HI  = 16'h0004,
		PH_XS_LO  = 16'h0008,
		PH_XE_HI  = 16'h0010,
		PH_XE_LO  = 16'h0020,
		PH_PASET  = 16'h0040,
		PH_YS_HI  = 16'h0080,
		PH_YS_LO  = 16'h0100,
		PH_YE_HI  = 16'h0200,
		PH_YE_LO  = 16'h0400,
		PH_RAMWR  = 16'h0800,
		PH_PIXEL  = 16'h1000,
		PH_MADCTL = 16'h2000,
		PH_MADPAR = 16'h4000,
		PH_INV    = 16'h8000
	} phase_t;

	// One result byte with its framing flags.
	typedef struct packed {
		logic [7:0] spi_byte;
		logic       is_data;
		logic       end_of_transfer;
		logic       last_byte;
	} out_item_t;

	// Memory-access-control parameter for a rotation.
	function automatic logic [7:0] madctl_param(input logic [1:0] rot);
		logic [7:0] p;
		case (rot)
			2'd0:    p = ACC_COL_FLIP | ACC_BGR_ORDER;
			2'd1:    p = ACC_AXIS_SWAP | ACC_BGR_ORDER;
			2'd2:    p = ACC_ROW_FLIP | ACC_BGR_ORDER;
			default: p = ACC_ROW_FLIP | ACC_COL_FLIP | ACC_AXIS_SWAP | ACC_BGR_ORDER;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/core/lfrbs_clip.sv @@
// Rectangle clipper: drops empty or off-screen rectangles and clips the rest
// to the panel. Depends on lfrbs_pkg.
`timescale 1ns / 1ps

module lfrbs_clip #(
	parameter int MAX_DIM = lfrbs_pkg::MAX_DIM_DEF,
	parameter int COORD_W = $clog2(MAX_DIM),
	parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
	input  logic signed [lfrbs_pkg::GEO_W-1:0]      x_lo,
	input  logic signed [lfrbs_pkg::GEO_W-1:0]      x_hi,
	input  logic signed [lfrbs_pkg::GEO_W-1:0]      y_lo,
	input  logic signed [lfrbs_pkg::GEO_W-1:0]      y_hi,
	input  logic                                    empty,
	input  logic [lfrbs_pkg::CFG_DATA_W-1:0]        panel_width,
	input  logic [lfrbs_pkg::CFG_DATA_W-1:0]        panel_height,
	output logic                                    keep,
	output logic [COORD_W-1:0]                      xs,
	output logic [COORD_W:0]                        xe,
	output logic [COORD_W-1:0]                      ys,
	output logic [COORD_W:0]                        ye,
	output logic [DIM_W-1:0]                        cw,
	output logic [DIM_W-1:0]                        ch
);
	import lfrbs_pkg::*;

	localparam int EXT_W = (CFG_DATA_W > DIM_W) ? CFG_DATA_W : DIM_W;
	localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_DIM);

	logic [EXT_W-1:0]        pw_ext, ph_ext;
	logic signed [GEO_W-1:0] pw_s, ph_s;
	logic signed [GEO_W-1:0] xs_g, xe_g, ys_g, ye_g, cw_g, ch_g;

	// Saturate panel size to the largest supported dimension
	always_comb begin
		pw_ext = EXT_W'(panel_width);
		ph_ext = EXT_W'(panel_height);
		if (pw_ext > MAX_EXT) pw_ext = MAX_EXT;
		if (ph_ext > MAX_EXT) ph_ext = MAX_EXT;
		pw_s = signed'(GEO_W'(pw_ext));
		ph_s = signed'(GEO_W'(ph_ext));
	end

	// Reject empty and fully off-screen rectangles
	assign keep = !empty && (x_lo < pw_s) && (y_lo < ph_s) && (x_hi >= 0) && (y_hi >= 0);

	// Clip each edge to the visible area
	always_comb begin
		xs_g = (x_lo < 0) ? '0 : x_lo;
		ys_g = (y_lo < 0) ? '0 : y_lo;
		xe_g = (x_hi >= pw_s) ? pw_s - GEO_W'(1) : x_hi;
		ye_g = (y_hi >= ph_s) ? ph_s - GEO_W'(1) : y_hi;
		cw_g = xe_g - xs_g + GEO_W'(1);
		ch_g = ye_g - ys_g + GEO_W'(1);
	end

	// End edges keep a sign bit: a zero panel size clips them to minus one
	assign xs = xs_g[COORD_W-1:0];
	assign xe = xe_g[COORD_W:0];
	assign ys = ys_g[COORD_W-1:0];
	assign ye = ye_g[COORD_W:0];
	assign cw = cw_g[DIM_W-1:0];
	assign ch = ch_g[DIM_W-1:0];

endmodule

@@ rtl/core/lcd_fill_rect_byte_sequencer_unit.sv @@
// Top level of the LCD fill-rectangle byte sequencer: input register, phase
// sequencer and two-entry output buffer. Depends on lfrbs_pkg and lfrbs_clip.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tdata: request fields, tuser: kind
//  m_*     | out       | m_tvalid/m_tready  | tdata: spi_byte, tlast: end_of_transfer,
//          |           |                    | tuser: is_data, last_byte
//  cfg_*   | in        | cfg_we             | cfg_index selects panel width or height
//
// One transaction per cycle is accepted while s_tready is high; a request is decoded in
// the cycle after acceptance, and an advance's byte is registered into the output buffer.
// The pixel count is formed by one multiply while the column command goes out.
// s_tready drops only when an advance waits in the input register while the sequencer
// is busy and both output buffer entries are full. Reset clears the sequencer to idle
// with an empty buffer and panel size 240 x 320.
`timescale 1ns / 1ps

module lcd_fill_rect_byte_sequencer_unit #(
	parameter int MAX_DIM = lfrbs_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lfrbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lfrbs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// rect_x[15:0], rect_y[31:16], rect_w[47:32], rect_h[63:48], fill_color[79:64],
	// rotation_sel[87:80], invert_on[88], zero fill [95:89]
	input  logic [lfrbs_pkg::S_TDATA_W-1:0]     s_tdata,
	// kind[1:0]
	input  logic [lfrbs_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// spi_byte[7:0]
	output logic [lfrbs_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                                m_tlast,
	// is_data[0], last_byte[1]
	output logic [lfrbs_pkg::M_TUSER_W-1:0]     m_tuser
);
	import lfrbs_pkg::*;

	localparam int COORD_W = $clog2(MAX_DIM);
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int PBL_W   = 2 * DIM_W + 1;

	// Configuration registers
	logic [CFG_DATA_W-1:0] panel_width_q, panel_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q  <= CFG_DATA_W'(240);
			panel_height_q <= CFG_DATA_W'(320);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PANEL_WIDTH:  panel_width_q  <= cfg_wdata;
				REG_PANEL_HEIGHT: panel_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Unpack and normalize the incoming request
	logic signed [FLD_W-1:0] in_x, in_y, in_w, in_h;
	logic signed [GEO_W-1:0] x_ext, y_ext, w_ext, h_ext;
	logic signed [GEO_W-1:0] x_lo_d, x_hi_d, y_lo_d, y_hi_d;

	assign in_x = signed'(s_tdata[OFS_RECT_X +: FLD_W]);
	assign in_y = signed'(s_tdata[OFS_RECT_Y +: FLD_W]);
	assign in_w = signed'(s_tdata[OFS_RECT_W +: FLD_W]);
	assign in_h = signed'(s_tdata[OFS_RECT_H +: FLD_W]);
	assign x_ext = GEO_W'(in_x);
	assign y_ext = GEO_W'(in_y);
	assign w_ext = GEO_W'(in_w);
	assign h_ext = GEO_W'(in_h);

	always_comb begin
		if (in_w[FLD_W-1]) begin
			x_lo_d = x_ext + w_ext + GEO_W'(1);
			x_hi_d = x_ext;
		end else begin
			x_lo_d = x_ext;
			x_hi_d = x_ext + w_ext - GEO_W'(1);
		end
		if (in_h[FLD_W-1]) begin
			y_lo_d = y_ext + h_ext + GEO_W'(1);
			y_hi_d = y_ext;
		end else begin
			y_lo_d = y_ext;
			y_hi_d = y_ext + h_ext - GEO_W'(1);
		end
	end

	// Input register
	logic                    valid_s1;
	kind_t                   kind_s1;
	logic signed [GEO_W-1:0] x_lo_s1, x_hi_s1, y_lo_s1, y_hi_s1;
	logic                    empty_s1;
	logic [FLD_W-1:0]        color_s1;
	logic [1:0]              rot_s1;
	logic                    inv_s1;
	logic                    stall_s1;
	logic                    in_fire;

	assign s_tready = !stall_s1;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1  <= kind_t'(s_tuser);
			x_lo_s1  <= x_lo_d;
			x_hi_s1  <= x_hi_d;
			y_lo_s1  <= y_lo_d;
			y_hi_s1  <= y_hi_d;
			empty_s1 <= (in_w == '0) || (in_h == '0);
			color_s1 <= s_tdata[OFS_COLOR +: FLD_W];
			rot_s1   <= s_tdata[OFS_ROT +: 2];
			inv_s1   <= s_tdata[OFS_INVERT];
		end
	end

	// Clip the registered rectangle
	logic               clip_keep;
	logic [COORD_W-1:0] clip_xs, clip_ys;
	logic [COORD_W:0]   clip_xe, clip_ye;
	logic [DIM_W-1:0]   clip_cw, clip_ch;

	lfrbs_clip #(
		.MAX_DIM (MAX_DIM),
		.COORD_W (COORD_W),
		.DIM_W   (DIM_W)
	) u_clip (
		.x_lo         (x_lo_s1),
		.x_hi         (x_hi_s1),
		.y_lo         (y_lo_s1),
		.y_hi         (y_hi_s1),
		.empty        (empty_s1),
		.panel_width  (panel_width_q),
		.panel_height (panel_height_q),
		.keep         (clip_keep),
		.xs           (clip_xs),
		.xe           (clip_xe),
		.ys           (clip_ys),
		.ye           (clip_ye),
		.cw           (clip_cw),
		.ch           (clip_ch)
	);

	// Sequencer state
	phase_t             phase_q, phase_d;
	logic [COORD_W-1:0] win_xs_q, win_ys_q;
	logic [COORD_W:0]   win_xe_q, win_ye_q;
	logic [DIM_W-1:0]   cw_q, ch_q;
	logic [FLD_W-1:0]   held_color_q;
	logic [PBL_W-1:0]   pbl_q, pbl_dec;
	logic [7:0]         pending_param_q;
	logic [2*DIM_W-1:0] area;
	logic [15:0]        xs16, xe16, ys16, ye16;

	logic      load_fill, load_rot, load_inv;
	logic      res_valid;
	out_item_t res;
	logic      buf_space;

	assign area    = cw_q * ch_q;
	assign pbl_dec = pbl_q - PBL_W'(1);
	assign xs16    = 16'(win_xs_q);
	assign xe16    = 16'(signed'(win_xe_q));
	assign ys16    = 16'(win_ys_q);
	assign ye16    = 16'(signed'(win_ye_q));

	// Hold an advance in the input register while busy with the output buffer full
	assign stall_s1 = valid_s1 && (kind_s1 == KIND_ADVANCE) && (phase_q != PH_IDLE)
		&& !buf_space;

	// Decode the request or emit the byte for the current phase
	always_comb begin
		phase_d             = phase_q;
		load_fill           = 1'b0;
		load_rot            = 1'b0;
		load_inv            = 1'b0;
		res_valid           = 1'b0;
		res.spi_byte        = '0;
		res.is_data         = 1'b1;
		res.end_of_transfer = 1'b0;
		res.last_byte       = 1'b0;
		if (valid_s1 && !stall_s1) begin
			if (kind_s1 != KIND_ADVANCE) begin
				if (phase_q == PH_IDLE) begin
					unique case (kind_s1)
						KIND_FILL: begin
							if (clip_keep) begin
								load_fill = 1'b1;
								phase_d   = PH_CASET;
							end
						end
						KIND_ROTATE: begin
							load_rot = 1'b1;
							phase_d  = PH_MADCTL;
						end
						default: begin
							load_inv = 1'b1;
							phase_d  = PH_INV;
						end
					endcase
				end
			end else if (phase_q != PH_IDLE) begin
				res_valid = 1'b1;
				unique case (phase_q)
					PH_CASET: begin
						res.spi_byte = CMD_CASET;
						res.is_data  = 1'b0;
						phase_d      = PH_XS_HI;
					end
					PH_XS_HI: begin
						res.spi_byte = xs16[15:8];
						phase_d      = PH_XS_LO;
					end
					PH_XS_LO: begin
						res.spi_byte = xs16[7:0];
						phase_d      = PH_XE_HI;
					end
					PH_XE_HI: begin
						res.spi_byte = xe16[15:8];
						phase_d      = PH_XE_LO;
					end
					PH_XE_LO: begin
						res.spi_byte        = xe16[7:0];
						res.end_of_transfer = 1'b1;
						phase_d             = PH_PASET;
					end
					PH_PASET: begin
						res.spi_byte = CMD_PASET;
						res.is_data  = 1'b0;
						phase_d      = PH_YS_HI;
					end
					PH_YS_HI: begin
						res.spi_byte = ys16[15:8];
						phase_d      = PH_YS_LO;
					end
					PH_YS_LO: begin
						res.spi_byte = ys16[7:0];
						phase_d      = PH_YE_HI;
					end
					PH_YE_HI: begin
						res.spi_byte = ye16[15:8];
						phase_d      = PH_YE_LO;
					end
					PH_YE_LO: begin
						res.spi_byte        = ye16[7:0];
						res.end_of_transfer = 1'b1;
						phase_d             = PH_RAMWR;
					end
					PH_RAMWR: begin
						res.spi_byte        = CMD_RAMWR;
						res.is_data         = 1'b0;
						res.end_of_transfer = 1'b1;
						if (pbl_q != '0) begin
							phase_d = PH_PIXEL;
						end else begin
							res.last_byte = 1'b1;
							phase_d       = PH_IDLE;
						end
					end
					PH_PIXEL: begin
						res.spi_byte = pbl_q[0] ? held_color_q[7:0] : held_color_q[15:8];
						if (pbl_dec == '0) begin
							res.end_of_transfer = 1'b1;
							res.last_byte       = 1'b1;
							phase_d             = PH_IDLE;
						end
					end
					PH_MADCTL: begin
						res.spi_byte = CMD_MADCTL;
						res.is_data  = 1'b0;
						phase_d      = PH_MADPAR;
					end
					PH_MADPAR: begin
						res.spi_byte        = pending_param_q;
						res.end_of_transfer = 1'b1;
						res.last_byte       = 1'b1;
						phase_d             = PH_IDLE;
					end
					PH_INV: begin
						res.spi_byte        = pending_param_q;
						res.is_data         = 1'b0;
						res.end_of_transfer = 1'b1;
						res.last_byte       = 1'b1;
						phase_d             = PH_IDLE;
					end
					default: begin
						res_valid = 1'b0;
					end
				endcase
			end
		end
	end

	// Advance the phase and latch request data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			win_xs_q        <= '0;
			win_xe_q        <= '0;
			win_ys_q        <= '0;
			win_ye_q        <= '0;
			cw_q            <= '0;
			ch_q            <= '0;
			held_color_q    <= '0;
			pbl_q           <= '0;
			pending_param_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (load_fill) begin
				win_xs_q     <= clip_xs;
				win_xe_q     <= clip_xe;
				win_ys_q     <= clip_ys;
				win_ye_q     <= clip_ye;
				cw_q         <= clip_cw;
				ch_q         <= clip_ch;
				held_color_q <= color_s1;
			end
			if (load_rot) begin
				pending_param_q <= madctl_param(rot_s1);
			end else if (load_inv) begin
				pending_param_q <= inv_s1 ? CMD_INVON : CMD_INVOFF;
			end
			// form the colour byte count while the column command waits
			if (phase_q == PH_CASET) begin
				pbl_q <= {area, 1'b0};
			end else if (res_valid && (phase_q == PH_PIXEL)) begin
				pbl_q <= pbl_dec;
			end
		end
	end

	// Two-entry output buffer
	out_item_t  buf_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       out_fire;

	assign buf_space = (cnt_q != 2'd2);
	assign m_tvalid  = (cnt_q != 2'd0);
	assign out_fire  = m_tvalid && m_tready;
	assign m_tdata   = buf_q[rd_ptr_q].spi_byte;
	assign m_tlast   = buf_q[rd_ptr_q].end_of_transfer;
	assign m_tuser   = {buf_q[rd_ptr_q].last_byte, buf_q[rd_ptr_q].is_data};

	always_ff @(posedge clk) begin
		if (res_valid) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (res_valid) wr_ptr_q <= !wr_ptr_q;
			if (out_fire)  rd_ptr_q <= !rd_ptr_q;
			case ({res_valid, out_fire})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ sim/lcd_fill_rect_byte_sequencer_unit_tb.sv @@
// Self-checking testbench for lcd_fill_rect_byte_sequencer_unit: a directed table
// followed by random request/advance traffic, checked byte by byte against a predictor.
// Depends on lfrbs_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module lcd_fill_rect_byte_sequencer_unit_tb;
	import lfrbs_pkg::*;

	localparam int MAX_DIM      = MAX_DIM_DEF;
	localparam int SETTLE       = 8;
	localparam int LIMIT_CYCLES = 3000000;
	localparam int PHASE_ITEMS  = 60;

	// One request or advance as it travels on the input stream.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] color;
		logic [7:0]  rot;
		logic        inv;
	} req_t;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_CFG,
		ROW_DRAIN
	} row_op_t;

	// Directed table row; exp_byte is used only where typed is set.
	typedef struct packed {
		row_op_t   op;
		req_t      req;
		cfg_reg_t  idx;
		logic [10:0] val;
		logic      typed;
		out_item_t exp_byte;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic [M_TUSER_W-1:0] m_tuser;

	// Predictor copy of the sequencer and its panel size.
	phase_t      seq_ph;
	logic [15:0] win_xs, win_xe, win_ys, win_ye;
	logic [15:0] held_color;
	logic [21:0] pix_left;
	logic [7:0]  held_param;
	logic [10:0] panel_w, panel_h;

	out_item_t pending_bytes[$];
	row_t      dir_rows[$];
	int        mismatch_count = 0;
	int        applied_items = 0;
	int        sender_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        cycle_count = 0;

	lcd_fill_rect_byte_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp_dim(input logic [10:0] reg_val);
		return (reg_val > MAX_DIM) ? MAX_DIM : int'(reg_val);
	endfunction

	// Apply one accepted transaction to the predicted sequencer; return 1 with
	// the byte it releases, if any.
	function automatic bit sequencer_step(input req_t r, output out_item_t res);
		int x, y, w, h, pw, ph, x2, y2;
		logic [7:0] b;
		logic d, e, l;
		res = '0;
		b = 8'h00;
		d = 1'b1;
		e = 1'b0;
		l = 1'b0;
		if (r.kind != KIND_ADVANCE) begin
			// drop any request while a sequence is still queued
			if (seq_ph != PH_IDLE) return 1'b0;
			applied_items++;
			case (r.kind)
				KIND_FILL: begin
					x = $signed(r.x);
					y = $signed(r.y);
					w = $signed(r.w);
					h = $signed(r.h);
					pw = clamp_dim(panel_w);
					ph = clamp_dim(panel_h);
					if (w == 0 || h == 0) return 1'b0;
					// normalize leftward / upward extents
					if (w < 0) begin
						x = x + w + 1;
						w = -w;
					end
					if (h < 0) begin
						y = y + h + 1;
						h = -h;
					end
					if (x >= pw || y >= ph) return 1'b0;
					x2 = x + w - 1;
					y2 = y + h - 1;
					if (x2 < 0 || y2 < 0) return 1'b0;
					// clip to the panel
					if (x < 0) begin
						x = 0;
						w = x2 + 1;
					end
					if (y < 0) begin
						y = 0;
						h = y2 + 1;
					end
					if (x2 >= pw) w = pw - x;
					if (y2 >= ph) h = ph - y;
					win_xs = 16'(x);
					win_xe = 16'(x + w - 1);
					win_ys = 16'(y);
					win_ye = 16'(y + h - 1);
					held_color = r.color;
					pix_left = 22'(w * h * 2);
					seq_ph = PH_CASET;
				end
				KIND_ROTATE: begin
					// rotations 0..3: MX|BGR, MV|BGR, MY|BGR, MY|MX|MV|BGR
					case (r.rot[1:0])
						2'd0:    held_param = 8'h48;
						2'd1:    held_param = 8'h28;
						2'd2:    held_param = 8'h88;
						default: held_param = 8'hE8;
					endcase
					seq_ph = PH_MADCTL;
				end
				default: begin
					held_param = r.inv ? CMD_INVON : CMD_INVOFF;
					seq_ph = PH_INV;
				end
			endcase
			return 1'b0;
		end
		// advance while idle releases nothing
		if (seq_ph == PH_IDLE) return 1'b0;
		applied_items++;
		case (seq_ph)
			PH_CASET:  begin b = CMD_CASET; d = 1'b0; seq_ph = PH_XS_HI; end
			PH_XS_HI:  begin b = win_xs[15:8]; seq_ph = PH_XS_LO; end
			PH_XS_LO:  begin b = win_xs[7:0]; seq_ph = PH_XE_HI; end
			PH_XE_HI:  begin b = win_xe[15:8]; seq_ph = PH_XE_LO; end
			PH_XE_LO:  begin b = win_xe[7:0]; e = 1'b1; seq_ph = PH_PASET; end
			PH_PASET:  begin b = CMD_PASET; d = 1'b0; seq_ph = PH_YS_HI; end
			PH_YS_HI:  begin b = win_ys[15:8]; seq_ph = PH_YS_LO; end
			PH_YS_LO:  begin b = win_ys[7:0]; seq_ph = PH_YE_HI; end
			PH_YE_HI:  begin b = win_ye[15:8]; seq_ph = PH_YE_LO; end
			PH_YE_LO:  begin b = win_ye[7:0]; e = 1'b1; seq_ph = PH_RAMWR; end
			PH_RAMWR: begin
				b = CMD_RAMWR;
				d = 1'b0;
				e = 1'b1;
				if (pix_left == 0) begin
					l = 1'b1;
					seq_ph = PH_IDLE;
				end else begin
					seq_ph = PH_PIXEL;
				end
			end
			PH_PIXEL: begin
				// high colour byte on even counts, low byte on odd
				b = pix_left[0] ? held_color[7:0] : held_color[15:8];
				if (pix_left != 0) pix_left = pix_left - 1'b1;
				if (pix_left == 0) begin
					e = 1'b1;
					l = 1'b1;
					seq_ph = PH_IDLE;
				end
			end
			PH_MADCTL: begin b = CMD_MADCTL; d = 1'b0; seq_ph = PH_MADPAR; end
			PH_MADPAR: begin b = held_param; e = 1'b1; l = 1'b1; seq_ph = PH_IDLE; end
			PH_INV: begin
				b = held_param;
				d = 1'b0;
				e = 1'b1;
				l = 1'b1;
				seq_ph = PH_IDLE;
			end
			default: return 1'b0;
		endcase
		res.spi_byte = b;
		res.is_data = d;
		res.end_of_transfer = e;
		res.last_byte = l;
		return 1'b1;
	endfunction

	function automatic row_t req_row(input kind_t k, input int x, input int y, input int w,
			input int h, input int color, input int rot, input int inv);
		row_t row;
		row = '0;
		row.op = ROW_ITEM;
		row.req.kind = k;
		row.req.x = 16'(x);
		row.req.y = 16'(y);
		row.req.w = 16'(w);
		row.req.h = 16'(h);
		row.req.color = 16'(color);
		row.req.rot = 8'(rot);
		row.req.inv = 1'(inv);
		return row;
	endfunction

	function automatic row_t adv_row(input bit typed, input logic [7:0] b, input bit d,
			input bit e, input bit l);
		row_t row;
		row = req_row(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0);
		row.typed = typed;
		row.exp_byte = '{b, d, e, l};
		return row;
	endfunction

	function automatic row_t ctl_row(input row_op_t op, input cfg_reg_t idx,
			input logic [10:0] val);
		row_t row;
		row = '0;
		row.op = op;
		row.idx = idx;
		row.val = val;
		return row;
	endfunction

	// Random item shaped by the predicted state: mostly advances while busy,
	// mostly requests (small well-formed fills, some noise) while idle.
	function automatic req_t make_item();
		req_t r;
		int pw, ph, roll;
		r.kind = KIND_ADVANCE;
		r.x = 16'($urandom);
		r.y = 16'($urandom);
		r.w = 16'($urandom);
		r.h = 16'($urandom);
		r.color = 16'($urandom);
		r.rot = 8'($urandom);
		r.inv = 1'($urandom);
		pw = clamp_dim(panel_w);
		ph = clamp_dim(panel_h);
		roll = $urandom_range(0, 99);
		if (seq_ph != PH_IDLE) begin
			if (roll < 8) r.kind = kind_t'($urandom_range(0, 2));
		end else if (roll < 12) begin
			r.kind = KIND_ADVANCE;
		end else if (roll < 30) begin
			r.kind = KIND_ROTATE;
		end else if (roll < 45) begin
			r.kind = KIND_INVERT;
		end else begin
			r.kind = KIND_FILL;
			// above the noise band: small rectangle near the panel
			if (roll >= 52) begin
				r.x = 16'(int'($urandom_range(0, pw + 12)) - 8);
				r.y = 16'(int'($urandom_range(0, ph + 12)) - 8);
				r.w = 16'(int'($urandom_range(0, 8)) - 4);
				r.h = 16'(int'($urandom_range(0, 8)) - 4);
			end
		end
		return r;
	endfunction

	function automatic req_t make_item_advance();
		req_t r;
		r = make_item();
		r.kind = KIND_ADVANCE;
		return r;
	endfunction

	// Present one transaction, wait for acceptance, and queue its predicted byte.
	task automatic send_item(input req_t r, input bit typed, input out_item_t exp_byte);
		out_item_t res;
		bit produced;
		while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, r.inv, r.rot, r.color, r.h, r.w, r.y, r.x};
		s_tuser <= r.kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		produced = sequencer_step(r, res);
		if (typed) pending_bytes.push_back(exp_byte);
		else if (produced) pending_bytes.push_back(res);
		@(negedge clk);
	endtask

	// Advance until the predicted sequence is empty.
	task automatic drain_sequence();
		while (seq_ph != PH_IDLE) send_item(make_item_advance(), 1'b0, '0);
	endtask

	// Drain, wait for all bytes, then let the block settle.
	task automatic wait_idle();
		drain_sequence();
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [10:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_PANEL_WIDTH) panel_w = val;
		else panel_h = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: randomly withhold tready per the current stall rate.
	always @(negedge clk) begin
		m_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Compare each output transaction with the oldest predicted byte.
	always @(posedge clk) begin : byte_check
		out_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected byte: spi_byte %h", m_tdata);
				mismatch_count++;
			end else begin
				want = pending_bytes.pop_front();
				if (m_tdata !== want.spi_byte) begin
					$error("spi_byte: expected %h, got %h", want.spi_byte, m_tdata);
					mismatch_count++;
				end
				if (m_tuser[0] !== want.is_data) begin
					$error("is_data: expected %b, got %b", want.is_data, m_tuser[0]);
					mismatch_count++;
				end
				if (m_tlast !== want.end_of_transfer) begin
					$error("end_of_transfer: expected %b, got %b", want.end_of_transfer, m_tlast);
					mismatch_count++;
				end
				if (m_tuser[1] !== want.last_byte) begin
					$error("last_byte: expected %b, got %b", want.last_byte, m_tuser[1]);
					mismatch_count++;
				end
			end
		end
	end

	// Hard stop on a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int start_cnt;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		seq_ph = PH_IDLE;
		win_xs = '0;
		win_xe = '0;
		win_ys = '0;
		win_ye = '0;
		held_color = '0;
		pix_left = '0;
		held_param = '0;
		panel_w = 11'd240;
		panel_h = 11'd320;

		// directed table, reset panel size 240 x 320
		dir_rows.push_back(adv_row(1'b0, 8'h00, 0, 0, 0));                 // advance while idle
		dir_rows.push_back(req_row(KIND_ROTATE, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(adv_row(1'b1, CMD_MADCTL, 0, 0, 0));
		dir_rows.push_back(adv_row(1'b1, 8'h48, 1, 1, 1));
		dir_rows.push_back(req_row(KIND_ROTATE, 0, 0, 0, 0, 0, 255, 0));
		dir_rows.push_back(req_row(KIND_INVERT, 0, 0, 0, 0, 0, 0, 1));     // busy, ignored
		dir_rows.push_back(adv_row(1'b1, CMD_MADCTL, 0, 0, 0));
		dir_rows.push_back(adv_row(1'b1, 8'hE8, 1, 1, 1));
		dir_rows.push_back(req_row(KIND_INVERT, 0, 0, 0, 0, 0, 0, 1));
		dir_rows.push_back(adv_row(1'b1, CMD_INVON, 0, 1, 1));
		dir_rows.push_back(req_row(KIND_INVERT, -1, -1, -1, -1, 65535, 255, 0));
		dir_rows.push_back(adv_row(1'b1, CMD_INVOFF, 0, 1, 1));
		dir_rows.push_back(req_row(KIND_FILL, -32768, -32768, 32767, 32767, 0, 0, 0));
		dir_rows.push_back(req_row(KIND_FILL, 0, 0, 0, 5, 0, 0, 0));      // empty
		dir_rows.push_back(req_row(KIND_FILL, 0, 0, 1, 1, 16'hABCD, 0, 0));
		dir_rows.push_back(adv_row(1'b1, CMD_CASET, 0, 0, 0));
		dir_rows.push_back(ctl_row(ROW_DRAIN, REG_PANEL_WIDTH, 11'd0));
		// top-left corner from extreme negative extents
		dir_rows.push_back(req_row(KIND_FILL, 3, 2, -32768, -32768, 16'hFFFF, 0, 0));
		dir_rows.push_back(req_row(KIND_FILL, 0, 0, 1, 1, 0, 0, 0));      // busy, ignored
		dir_rows.push_back(ctl_row(ROW_DRAIN, REG_PANEL_WIDTH, 11'd0));
		dir_rows.push_back(req_row(KIND_FILL, -5, -5, 7, 7, 16'h1234, 0, 0));
		dir_rows.push_back(ctl_row(ROW_DRAIN, REG_PANEL_WIDTH, 11'd0));
		dir_rows.push_back(req_row(KIND_FILL, 32767, 0, 1, 1, 0, 0, 0));  // off-screen
		dir_rows.push_back(ctl_row(ROW_CFG, REG_PANEL_WIDTH, 11'd0));
		dir_rows.push_back(req_row(KIND_FILL, 0, 0, 5, 5, 0, 0, 0));      // zero width panel
		// straddles the left edge of a zero width panel: column end wraps to all ones
		dir_rows.push_back(req_row(KIND_FILL, -5, 0, 7, 5, 16'h0F0F, 0, 0));
		dir_rows.push_back(ctl_row(ROW_DRAIN, REG_PANEL_WIDTH, 11'd0));
		dir_rows.push_back(ctl_row(ROW_CFG, REG_PANEL_WIDTH, 11'd2047));  // saturates
		dir_rows.push_back(req_row(KIND_FILL, 1000, 300, 100, 2, 16'h5AA5, 0, 0));
		dir_rows.push_back(ctl_row(ROW_DRAIN, REG_PANEL_WIDTH, 11'd0));

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].op)
				ROW_ITEM:  send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].exp_byte);
				ROW_CFG:   cfg_write(dir_rows[i].idx, dir_rows[i].val);
				default:   drain_sequence();
			endcase
		end

		// random phases: idling pattern and panel size change per phase
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					cfg_write(REG_PANEL_WIDTH, 11'd64);
					cfg_write(REG_PANEL_HEIGHT, 11'd48);
					sender_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					cfg_write(REG_PANEL_WIDTH, 11'd2047);
					cfg_write(REG_PANEL_HEIGHT, 11'd1);
					sender_idle_pct = 64;
					recv_stall_pct = 0;
				end
				2: begin
					cfg_write(REG_PANEL_WIDTH, 11'd1);
					cfg_write(REG_PANEL_HEIGHT, 11'd1024);
					sender_idle_pct = 0;
					recv_stall_pct = 64;
				end
				default: begin
					cfg_write(REG_PANEL_WIDTH, 11'd1024);
					cfg_write(REG_PANEL_HEIGHT, 11'd8);
					sender_idle_pct = 29;
					recv_stall_pct = 29;
				end
			endcase
			start_cnt = applied_items;
			while (applied_items - start_cnt < PHASE_ITEMS) send_item(make_item(), 1'b0, '0);
		end

		wait_idle();
		if (mismatch_count == 0 && pending_bytes.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
